// File: design/plle_pkg.sv
package plle_pkg;

	// opcodes of an input request
	localparam logic [1:0] OP_MSG   = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_OWN_ID  = 3'd0;
	localparam logic [2:0] CFG_RANGE   = 3'd1;
	localparam logic [2:0] CFG_TIMEOUT = 3'd2;
	localparam logic [2:0] CFG_OWN_X   = 3'd3;
	localparam logic [2:0] CFG_OWN_Y   = 3'd4;
	localparam logic [2:0] CFG_OWN_Z   = 3'd5;

	localparam logic signed [3:0] LEADER_NONE = -4'sd1;
	localparam logic [15:0] AGE_MAX = 16'hffff;

	localparam logic [33:0] RANGE_RST   = 34'd2359296;
	localparam logic [15:0] TIMEOUT_RST = 16'd30;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_ACC,
		ST_RANGE,
		ST_TICK,
		ST_CHECK,
		ST_ELECT,
		ST_DONE
	} state_t;

endpackage

// File: design/peer_liveness_leader_election_core.sv
// sequence: a status message passes three times through subtract, square and accumulate
// on one 17x17 multiplier, then the range compare; a tick walks the peer table once, a
// check walks it, then may walk it again for the election (one peer slot a cycle)
// one request at a time: the next is taken in the cycle after the result is registered
// reset: arst_n clears the sequencer, peer table and leader at once and loads register defaults
module peer_liveness_leader_election_core import plle_pkg::*; #(
	parameter int NUM_NODES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [2:0]          peer_id,
	input  logic signed [15:0]  peer_x,
	input  logic signed [15:0]  peer_y,
	input  logic signed [15:0]  peer_z,
	input  logic signed [3:0]   peer_claim,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [3:0]   leader,
	output logic [7:0]          connected_mask,
	output logic                message_accepted,
	output logic                leader_changed,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [33:0]         cfg_data
);

	localparam int IW = (NUM_NODES > 2) ? $clog2(NUM_NODES) : 1;

	// configuration registers
	logic [2:0]         own_id_q;
	logic [33:0]        range_q;
	logic [15:0]        timeout_q;
	logic signed [15:0] own_x_q, own_y_q, own_z_q;

	// peer table and election state
	logic [NUM_NODES-1:0] conn_q;
	logic [15:0]          age_q [NUM_NODES];
	logic signed [3:0]    claimed_q [NUM_NODES];
	logic signed [3:0]    leader_q;

	// latched request
	logic [1:0]         op_q;
	logic [2:0]         pid_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic signed [3:0]  claim_q;
	logic signed [3:0]  before_q;

	// sequencer and shared arithmetic
	state_t             state_q, state_d;
	logic [IW-1:0]      idx_q;
	logic [1:0]         axis_q;
	logic signed [16:0] diff_q;
	logic [31:0]        prod_q;
	logic [33:0]        acc_q;
	logic               hit_q;
	logic               any_q;
	logic [IW-1:0]      first_q;

	// result register
	logic               out_valid_q;
	logic signed [3:0]  out_leader_q;
	logic [7:0]         out_mask_q;
	logic               out_acc_q;
	logic               out_chg_q;

	// combinational helpers
	logic               accept;
	logic               load_out;
	logic               walk_last;
	logic               axis_last;
	logic [IW-1:0]      pid_idx;
	logic               pid_ok;
	logic               msg_store;
	logic signed [15:0] coord_peer, coord_own;
	logic signed [33:0] prod_w;
	logic signed [3:0]  claim_cur;
	logic               adopt;
	logic               keep_leader;
	logic signed [3:0]  lowest;
	logic               survive;
	logic [7:0]         mask_w;

	// alive set: own id plus every connected peer slot
	function automatic logic is_alive(input logic signed [3:0] id, input logic [2:0] own,
			input logic [NUM_NODES-1:0] conn);
		logic [IW-1:0] ix;
		logic          res;
		ix = IW'({{IW{1'b0}}, id});
		if (id[3]) begin
			res = 1'b0;
		end else if (id[2:0] == own) begin
			res = 1'b1;
		end else if (32'(id[2:0]) >= NUM_NODES) begin
			res = 1'b0;
		end else begin
			res = conn[ix];
		end
		return res;
	endfunction

	assign accept    = in_valid && !in_stall;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign walk_last = (idx_q == IW'(NUM_NODES - 1));
	assign axis_last = (axis_q == 2'd2);

	// sender slot, ignored when it is our own id or beyond the table
	assign pid_idx   = IW'({{IW{1'b0}}, pid_q});
	assign pid_ok    = (pid_q != own_id_q) && (32'(pid_q) < NUM_NODES);
	assign msg_store = (state_q == ST_RANGE) && pid_ok && (acc_q <= range_q);

	// axis select feeding the shared subtractor
	always_comb begin
		unique case (axis_q)
			2'd0: begin
				coord_peer = px_q;
				coord_own  = own_x_q;
			end
			2'd1: begin
				coord_peer = py_q;
				coord_own  = own_y_q;
			end
			default: begin
				coord_peer = pz_q;
				coord_own  = own_z_q;
			end
		endcase
	end

	// the one multiplier: |diff| < 2^16, so the square fits in 32 bits
	assign prod_w = diff_q * diff_q;

	// election walk decisions
	assign claim_cur   = claimed_q[idx_q];
	assign adopt       = conn_q[idx_q] && !claim_cur[3] && (claim_cur != leader_q)
		&& is_alive(claim_cur, own_id_q, conn_q);
	assign keep_leader = (leader_q != LEADER_NONE) && is_alive(leader_q, own_id_q, conn_q);
	assign lowest      = (32'(first_q) < 32'(own_id_q)) ? 4'(first_q) : {1'b0, own_id_q};

	// a peer that is still connected after the timeout test
	assign survive = conn_q[idx_q] && !(age_q[idx_q] > timeout_q);

	// only the first eight slots are shown in the mask
	for (genvar g = 0; g < 8; g++) begin : g_mask
		if (g < NUM_NODES) begin : g_on
			assign mask_w[g] = conn_q[g];
		end else begin : g_off
			assign mask_w[g] = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
				if (in_valid) begin
					unique case (opcode)
						OP_MSG:   state_d = ST_DIFF;
						OP_TICK:  state_d = ST_TICK;
						OP_CHECK: state_d = ST_CHECK;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = axis_last ? ST_RANGE : ST_DIFF;
			ST_RANGE: state_d = ST_DONE;
			ST_TICK: begin
				if (walk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_CHECK: begin
				// a lone node keeps its leader, so the election is skipped
				if (walk_last) begin
					state_d = (any_q || survive) ? ST_ELECT : ST_DONE;
				end
			end
			ST_ELECT: begin
				if (adopt || walk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= '0;
			range_q   <= RANGE_RST;
			timeout_q <= TIMEOUT_RST;
			own_x_q   <= '0;
			own_y_q   <= '0;
			own_z_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_ID:  own_id_q  <= cfg_data[2:0];
				CFG_RANGE:   range_q   <= cfg_data;
				CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
				CFG_OWN_X:   own_x_q   <= cfg_data[15:0];
				CFG_OWN_Y:   own_y_q   <= cfg_data[15:0];
				CFG_OWN_Z:   own_z_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// request latch and arithmetic registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			pid_q    <= peer_id;
			px_q     <= peer_x;
			py_q     <= peer_y;
			pz_q     <= peer_z;
			claim_q  <= peer_claim;
			before_q <= leader_q;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= {coord_peer[15], coord_peer} - {coord_own[15], coord_own};
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_w[31:0];
		end
	end

	// counters, walk flags and the peer table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			axis_q   <= '0;
			acc_q    <= '0;
			hit_q    <= 1'b0;
			any_q    <= 1'b0;
			first_q  <= '0;
			conn_q   <= '0;
			leader_q <= LEADER_NONE;
			for (int i = 0; i < NUM_NODES; i++) begin
				age_q[i]     <= '0;
				claimed_q[i] <= LEADER_NONE;
			end
		end else begin
			if (accept) begin
				idx_q  <= '0;
				axis_q <= '0;
				acc_q  <= '0;
				hit_q  <= 1'b0;
				any_q  <= 1'b0;
			end
			unique case (state_q)
				ST_ACC: begin
					acc_q  <= acc_q + 34'(prod_q);
					axis_q <= axis_q + 2'd1;
				end
				ST_RANGE: begin
					if (msg_store) begin
						age_q[pid_idx]     <= '0;
						claimed_q[pid_idx] <= claim_q;
						conn_q[pid_idx]    <= 1'b1;
						hit_q              <= 1'b1;
					end
				end
				ST_TICK: begin
					if (age_q[idx_q] != AGE_MAX) begin
						age_q[idx_q] <= age_q[idx_q] + 16'd1;
					end
					idx_q <= walk_last ? '0 : idx_q + IW'(1);
				end
				ST_CHECK: begin
					if (!survive) begin
						conn_q[idx_q] <= 1'b0;
					end
					// first surviving slot gives the lowest peer id
					if (survive && !any_q) begin
						any_q   <= 1'b1;
						first_q <= idx_q;
					end
					idx_q <= walk_last ? '0 : idx_q + IW'(1);
				end
				ST_ELECT: begin
					if (adopt) begin
						leader_q <= claim_cur;
					end else if (walk_last && !keep_leader) begin
						leader_q <= lowest;
					end
					idx_q <= idx_q + IW'(1);
				end
				default: ;
			endcase
		end
	end

	// result register, holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_leader_q <= leader_q;
			out_mask_q   <= mask_w;
			out_acc_q    <= hit_q;
			out_chg_q    <= (leader_q != before_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign leader           = out_leader_q;
	assign connected_mask   = out_mask_q;
	assign message_accepted = out_acc_q;
	assign leader_changed   = out_chg_q;

`ifndef SYNTHESIS
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");

	a_store_connects: assert property (@(posedge clk) disable iff (!arst_n)
		msg_store |=> conn_q[$past(pid_idx)])
		else $error("stored message did not connect its peer");

	a_leader_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		leader_q != LEADER_NONE |=> leader_q != LEADER_NONE)
		else $error("leader fell back to none");

	a_hit_only_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && hit_q) |-> op_q == OP_MSG)
		else $error("message flag set for a non-message request");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK || state_q == ST_CHECK || state_q == ST_ELECT)
			|-> 32'(idx_q) < NUM_NODES)
		else $error("walk index beyond the peer table");
`endif

endmodule

// File: sim/tb_peer_liveness_leader_election_core.sv
module tb_peer_liveness_leader_election_core import plle_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// opcode with no meaning, the block only reports its state
	localparam logic [1:0] OP_SPARE = 2'd3;
	// the longest request is a check, which can walk the peer slots twice
	localparam int SETTLE = 2 * 8 + 4;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 180;
	localparam logic [33:0] RANGE_MAX = '1;

	typedef struct {
		logic [1:0]         op;
		logic [2:0]         id;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [3:0]  claim;
	} request_t;

	typedef struct {
		logic signed [3:0] leader;
		logic [7:0]        mask;
		logic              accepted;
		logic              changed;
	} status_t;

	// rows of the directed table: a predicted request, a request with a typed
	// expectation, or a register write
	typedef enum {ROW_SEND, ROW_SEND_KNOWN, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		request_t    req;
		logic [2:0]  reg_idx;
		logic [33:0] reg_val;
		status_t     want;
	} row_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_TICK;
	logic [2:0]         peer_id = '0;
	logic signed [15:0] peer_x = '0;
	logic signed [15:0] peer_y = '0;
	logic signed [15:0] peer_z = '0;
	logic signed [3:0]  peer_claim = '0;

	// result channel
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [3:0] leader;
	logic [7:0]        connected_mask;
	logic              message_accepted;
	logic              leader_changed;

	// configuration write channel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_OWN_ID;
	logic [33:0] cfg_data = '0;

	// predictor copy of the registers
	logic [2:0]         my_id;
	logic [33:0]        reach_sq;
	logic [15:0]        silence_limit;
	logic signed [15:0] my_x;
	logic signed [15:0] my_y;
	logic signed [15:0] my_z;

	// predictor copy of the peer table
	logic signed [3:0] leader_now;
	logic [7:0]        linked;
	logic [15:0]       silence [8];
	logic signed [3:0] believed [8];

	// expected results, oldest first, and the directed table
	status_t status_q [$];
	row_t    script [$];
	status_t due;

	int errors = 0;
	int cycles = 0;
	int idle_before = 0;
	int stall_left = 0;
	// a calm phase runs with no gaps on either side
	bit calm = 1'b0;

	peer_liveness_leader_election_core dut (.*);

	always #5ns clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic bit node_alive(int id);
		if (id < 0)
			return 1'b0;
		if (id == int'(my_id))
			return 1'b1;
		return linked[id];
	endfunction

	function automatic void run_election();
		int lowest;
		int c;
		bit any_peer;
		lowest = int'(my_id);
		any_peer = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (linked[i]) begin
				any_peer = 1'b1;
				if (i < lowest)
					lowest = i;
			end
		end
		// alone: leader stays as it is
		if (!any_peer)
			return;
		// first live claim that differs from the current leader wins
		for (int i = 0; i < 8; i++) begin
			c = int'(believed[i]);
			if (linked[i] && c >= 0 && c != int'(leader_now) && node_alive(c)) begin
				leader_now = 4'(c);
				return;
			end
		end
		if (leader_now != LEADER_NONE && node_alive(int'(leader_now)))
			return;
		leader_now = 4'(lowest);
	endfunction

	function automatic status_t track_request(request_t r);
		status_t s;
		logic signed [3:0] prior;
		longint dx;
		longint dy;
		longint dz;
		prior = leader_now;
		s.accepted = 1'b0;
		case (r.op)
		OP_MSG: begin
			dx = longint'(r.x) - longint'(my_x);
			dy = longint'(r.y) - longint'(my_y);
			dz = longint'(r.z) - longint'(my_z);
			// squared distance compare, no root
			if (r.id != my_id && dx * dx + dy * dy + dz * dz <= longint'(reach_sq)) begin
				silence[r.id] = '0;
				believed[r.id] = r.claim;
				linked[r.id] = 1'b1;
				s.accepted = 1'b1;
			end
		end
		OP_TICK: begin
			for (int i = 0; i < 8; i++)
				if (silence[i] != AGE_MAX)
					silence[i] = silence[i] + 16'd1;
		end
		OP_CHECK: begin
			for (int i = 0; i < 8; i++)
				if (linked[i] && silence[i] > silence_limit)
					linked[i] = 1'b0;
			run_election();
		end
		default: begin
		end
		endcase
		s.leader = leader_now;
		s.mask = linked;
		s.changed = (leader_now != prior);
		return s;
	endfunction

	function automatic void store_setting(logic [2:0] idx, logic [33:0] v);
		case (idx)
		CFG_OWN_ID:  my_id = v[2:0];
		CFG_RANGE:   reach_sq = v;
		CFG_TIMEOUT: silence_limit = v[15:0];
		CFG_OWN_X:   my_x = v[15:0];
		CFG_OWN_Y:   my_y = v[15:0];
		CFG_OWN_Z:   my_z = v[15:0];
		default: begin
		end
		endcase
	endfunction

	// ---------------------------------------------------------------- random picks

	// run length: mostly short, now and then long
	function automatic int pick_run();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic int pick_gap();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return pick_run();
	endfunction

	// sender coordinate: on the own position, around it, or anywhere
	function automatic logic signed [15:0] near_axis(logic signed [15:0] c, int mode);
		int v;
		if (mode < 2)
			v = int'(c);
		else if (mode < 8)
			v = int'(c) + int'($urandom_range(0, 3200)) - 1600;
		else
			v = int'($urandom_range(0, 65535)) - 32768;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 3))
		0: return 16'h7fff;
		1: return 16'h8000;
		2: return 16'($urandom);
		default: return 16'($urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	// mostly in-range status messages mixed with ticks, checks and the odd spare opcode
	function automatic request_t random_request();
		request_t r;
		int roll;
		int mode;
		roll = $urandom_range(0, 99);
		r.op = roll < 55 ? OP_MSG : roll < 78 ? OP_TICK : roll < 97 ? OP_CHECK : OP_SPARE;
		r.id = 3'($urandom_range(0, 7));
		mode = $urandom_range(0, 9);
		r.x = near_axis(my_x, mode);
		r.y = near_axis(my_y, mode);
		r.z = near_axis(my_z, mode);
		// occasionally any 4-bit claim, odd negatives included
		if ($urandom_range(0, 7) == 0)
			r.claim = 4'($urandom);
		else
			r.claim = 4'($urandom_range(0, 8) - 1);
		return r;
	endfunction

	// ---------------------------------------------------------------- directed table

	function automatic void plan_send(logic [1:0] op, logic [2:0] id, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, logic signed [3:0] claim);
		row_t row;
		row.kind = ROW_SEND;
		row.req.op = op;
		row.req.id = id;
		row.req.x = x;
		row.req.y = y;
		row.req.z = z;
		row.req.claim = claim;
		row.reg_idx = CFG_OWN_ID;
		row.reg_val = '0;
		script.insert(script.size(), row);
	endfunction

	function automatic void plan_known(logic [1:0] op, logic [2:0] id, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, logic signed [3:0] claim,
			logic signed [3:0] ldr, logic [7:0] mask, logic acc, logic chg);
		row_t row;
		plan_send(op, id, x, y, z, claim);
		row = script.pop_back();
		row.kind = ROW_SEND_KNOWN;
		row.want.leader = ldr;
		row.want.mask = mask;
		row.want.accepted = acc;
		row.want.changed = chg;
		script.insert(script.size(), row);
	endfunction

	function automatic void plan_write(logic [2:0] idx, logic [33:0] v);
		row_t row;
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = v;
		script.insert(script.size(), row);
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic flag(string what);
		errors++;
		$display("tb: mismatch at %0t: %s", $realtime, what);
	endtask

	// one request: wait out the gap, hold it until taken, then predict.
	// valid stays up when the next request follows with no gap
	task automatic send_request(request_t r, bit known, status_t want);
		status_t guess;
		repeat (idle_before) @(posedge clk);
		in_valid <= 1'b1;
		opcode <= r.op;
		peer_id <= r.id;
		peer_x <= r.x;
		peer_y <= r.y;
		peer_z <= r.z;
		peer_claim <= r.claim;
		do @(posedge clk); while (in_stall);
		guess = track_request(r);
		status_q.insert(status_q.size(), known ? want : guess);
		idle_before = pick_gap();
		if (idle_before != 0)
			in_valid <= 1'b0;
	endtask

	// caller lowers cfg_valid after the last write of a batch
	task automatic write_setting(logic [2:0] idx, logic [33:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		store_setting(idx, v);
	endtask

	// stop requests, let every outstanding result drain, then let the block go quiet
	task automatic settle();
		if (idle_before == 0) begin
			in_valid <= 1'b0;
			idle_before = 1;
		end
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side back-pressure in runs of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (calm) begin
			out_stall <= 1'b0;
			stall_left <= 16;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_left <= pick_run();
		end
	end

	// every taken result against the oldest expectation, field by field
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				flag("result with no request outstanding");
			end else begin
				due = status_q.pop_front();
				if (leader !== due.leader || connected_mask !== due.mask ||
						message_accepted !== due.accepted || leader_changed !== due.changed)
					flag($sformatf("leader %0d/%0d mask %h/%h accepted %b/%b changed %b/%b",
						leader, due.leader, connected_mask, due.mask,
						message_accepted, due.accepted, leader_changed, due.changed));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		row_t row;
		status_t blank;
		bit writing;
		blank.leader = LEADER_NONE;
		blank.mask = '0;
		blank.accepted = 1'b0;
		blank.changed = 1'b0;
		writing = 1'b0;

		// predictor starts from the reset values
		my_id = '0;
		reach_sq = RANGE_RST;
		silence_limit = TIMEOUT_RST;
		my_x = '0;
		my_y = '0;
		my_z = '0;
		leader_now = LEADER_NONE;
		linked = '0;
		for (int i = 0; i < 8; i++) begin
			silence[i] = '0;
			believed[i] = LEADER_NONE;
		end

		// fresh out of reset: a lone node, nothing changes
		plan_known(OP_CHECK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0, LEADER_NONE, 8'h00, 1'b0, 1'b0);
		plan_known(OP_TICK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0, LEADER_NONE, 8'h00, 1'b0, 1'b0);
		plan_known(OP_SPARE, 3'd5, 16'sh7fff, 16'sh8000, 16'sh7fff, 4'sd7,
			LEADER_NONE, 8'h00, 1'b0, 1'b0);
		// message carrying the own id is ignored
		plan_known(OP_MSG, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0, LEADER_NONE, 8'h00, 1'b0, 1'b0);
		// exactly at the 6 m range is kept, one unit beyond is dropped
		plan_known(OP_MSG, 3'd3, 16'sd1536, 16'sd0, 16'sd0, LEADER_NONE,
			LEADER_NONE, 8'h08, 1'b1, 1'b0);
		plan_known(OP_MSG, 3'd5, 16'sd1537, 16'sd0, 16'sd0, 4'sd2, LEADER_NONE, 8'h08, 1'b0, 1'b0);
		// no claims, no leader: lowest alive id wins
		plan_known(OP_CHECK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0, 4'sd0, 8'h08, 1'b0, 1'b1);
		// claim for a peer that is alive gets adopted; odd negative claim means none
		plan_send(OP_MSG, 3'd2, 16'sd0, 16'sd0, -16'sd1536, 4'sd7);
		plan_send(OP_MSG, 3'd7, 16'sd0, 16'sd1536, 16'sd0, 4'sh8);
		plan_send(OP_CHECK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0);
		// extreme settings: widest range, zero timeout, node in a corner
		plan_write(CFG_OWN_ID, 34'd7);
		plan_write(CFG_RANGE, RANGE_MAX);
		plan_write(CFG_TIMEOUT, 34'd0);
		plan_write(CFG_OWN_X, 34'h0_7fff);
		plan_write(CFG_OWN_Y, 34'h0_8000);
		plan_write(CFG_OWN_Z, 34'h0_7fff);
		// farthest possible sender still fits the widest range
		plan_send(OP_MSG, 3'd0, 16'sh8000, 16'sh7fff, 16'sh8000, 4'sd7);
		// zero timeout: one tick loses every peer, leader held while alone
		plan_send(OP_TICK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0);
		plan_send(OP_CHECK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0);
		plan_send(OP_MSG, 3'd7, 16'sh7fff, 16'sh8000, 16'sh7fff, 4'sd1);
		// zero range: only a sender on the very spot gets through
		plan_write(CFG_RANGE, 34'd0);
		plan_write(CFG_TIMEOUT, 34'h0_ffff);
		plan_send(OP_MSG, 3'd1, 16'sh7fff, 16'sh8000, 16'sh7fff, 4'sd3);
		plan_send(OP_MSG, 3'd4, 16'sh7ffe, 16'sh8000, 16'sh7fff, 4'sd4);
		plan_send(OP_TICK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0);
		plan_send(OP_CHECK, 3'd0, 16'sd0, 16'sd0, 16'sd0, 4'sd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; a batch of writes waits for the block to go idle
		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing)
					settle();
				writing = 1'b1;
				write_setting(row.reg_idx, row.reg_val);
			end else begin
				if (writing)
					cfg_valid <= 1'b0;
				writing = 1'b0;
				send_request(row.req, row.kind == ROW_SEND_KNOWN, row.want);
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle();
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0)
				write_setting(CFG_OWN_ID, 34'($urandom_range(0, 7)));
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 4))
				0: write_setting(CFG_RANGE, 34'd0);
				1: write_setting(CFG_RANGE, RANGE_MAX);
				2: write_setting(CFG_RANGE, RANGE_RST);
				3: write_setting(CFG_RANGE, 34'($urandom_range(0, 1 << 24)));
				default: write_setting(CFG_RANGE, {2'($urandom), 32'($urandom)});
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 3))
				0: write_setting(CFG_TIMEOUT, 34'd0);
				1: write_setting(CFG_TIMEOUT, 34'h0_ffff);
				2: write_setting(CFG_TIMEOUT, 34'($urandom_range(1, 8)));
				default: write_setting(CFG_TIMEOUT, 34'($urandom_range(9, 60)));
				endcase
			end
			if ($urandom_range(0, 2) != 0)
				write_setting(CFG_OWN_X, {18'd0, pick_coord()});
			if ($urandom_range(0, 2) != 0)
				write_setting(CFG_OWN_Y, {18'd0, pick_coord()});
			if ($urandom_range(0, 2) != 0)
				write_setting(CFG_OWN_Z, {18'd0, pick_coord()});
			cfg_valid <= 1'b0;
			repeat (PHASE_REQUESTS)
				send_request(random_request(), 1'b0, blank);
		end

		settle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
